@@ src/power_meter_frame_decoder_top_assert.svh @@
// Assertion macros shared by the power meter frame decoder RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef POWER_METER_FRAME_DECODER_TOP_ASSERT_SVH
`define POWER_METER_FRAME_DECODER_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PMFD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmfd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PMFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmfd assertion failed");

`endif

@@ src/pmfd_pkg.sv @@
// Shared constants for the power meter frame decoder.
// No dependencies; used by the divider and the top level.
package pmfd_pkg;

    localparam int DVD_W = 56;   // param (24 bits) times coefficient (32 bits)
    localparam int DSR_W = 24;   // data field width
    localparam int VAL_W = 32;   // Q16.16 result width
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] SAT32 = '1;

    localparam logic [7:0] HDR_NORMAL  = 8'h55;
    localparam logic [7:0] HDR_MIN_ALT = 8'hF0;
    localparam logic [7:0] SYNC_BYTE   = 8'h5A;
    localparam logic [4:0] FIELD_FIRST = 5'd2;
    localparam logic [4:0] FIELD_LAST  = 5'd19;
    localparam logic [4:0] CHECK_BYTE  = 5'd23;

    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

endpackage

@@ src/pmfd_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on pmfd_pkg; the quotient saturates to 32 bits.
module pmfd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pmfd_pkg::DVD_W-1:0]  dividend,
    input  logic [pmfd_pkg::DSR_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [pmfd_pkg::VAL_W-1:0]  quotient
);
    import pmfd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

    dv_state_t          state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DSR_W-1:0]   dsr_reg;
    logic [DSR_W-1:0]   rem_reg;
    logic               done_reg;
    logic [DSR_W:0]     trial;
    logic               fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            count_reg <= '0;
            dvd_reg   <= '0;
            dsr_reg   <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= dividend;
                        dsr_reg   <= divisor;
                        rem_reg   <= '0;
                        count_reg <= CNT_W'(DVD_W - 1);
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    if (fits)
                        rem_reg <= DSR_W'(trial - {1'b0, dsr_reg});
                    else
                        rem_reg <= trial[DSR_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
                    if (count_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                    else
                        count_reg <= count_reg - 1'b1;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg == DV_RUN);
    assign done     = done_reg;
    assign quotient = (|dvd_reg[DVD_W-1:VAL_W]) ? SAT32 : dvd_reg[VAL_W-1:0];

endmodule

@@ src/power_meter_frame_decoder_top.sv @@
// Top level of the power meter frame decoder: framing, checksum and sequencer.
// Depends on pmfd_pkg, pmfd_div and power_meter_frame_decoder_top_assert.svh.
//
// Usage: serial bytes from the metering chip enter on the s_axis channel, one
// byte per transfer. The block hunts for a state byte (0x55 or 0xF0 and up)
// followed by 0x5A and then collects 22 more bytes, taken back to back while
// the sequencer is idle. After the checksum byte the input stalls while one
// shared 32x32 multiplier and one bit-serial divider compute voltage, current
// and power in turn; the divider's 56 steps per channel dominate that work,
// and the result transfer is then offered on m_axis. A zero data field skips
// its division. The result sits in an output register;
// bytes of the next frame are taken while it waits, but the checksum byte of
// the next frame is held off until the previous result has been taken.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// belong in idle time.
// Reset returns the framer to hunting, clears the output valid and sets all
// four coefficients to 1.0 (Q16.16).
`include "power_meter_frame_decoder_top_assert.svh"

module power_meter_frame_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] state_byte, [9:8] status, [41:10] voltage, [73:42] current,
    // [105:74] power, [111:106] zero
    output logic [111:0]                      m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [pmfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmfd_pkg::VAL_W-1:0]        cfg_data
);
    import pmfd_pkg::*;

    typedef enum logic [1:0] {PH_HUNT, PH_SYNC, PH_COLLECT} phase_t;
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_MUL, SQ_DIV_GO, SQ_DIV_WAIT, SQ_SC_MUL, SQ_SC_SAT, SQ_NEXT, SQ_OUT
    } seq_t;

    // Configuration registers.
    logic [VAL_W-1:0] voltage_coef_reg, current_coef_reg, current_gain_reg, power_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_coef_reg <= VAL_W'(32'h0001_0000);
            current_coef_reg <= VAL_W'(32'h0001_0000);
            current_gain_reg <= VAL_W'(32'h0001_0000);
            power_gain_reg   <= VAL_W'(32'h0001_0000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLTAGE_COEF: voltage_coef_reg <= cfg_data;
                REG_CURRENT_COEF: current_coef_reg <= cfg_data;
                REG_CURRENT_GAIN: current_gain_reg <= cfg_data;
                REG_POWER_GAIN:   power_gain_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Framer. The six fields shift in as one line, so after byte 19 the
    // first field sits at the top and each field has a fixed place.
    phase_t        phase_reg;
    logic [4:0]    idx_reg;
    logic [7:0]    hold_reg;
    logic [7:0]    sum_reg;
    logic [143:0]  fields_reg;
    logic          sum_ok_reg;
    seq_t          sq_reg;
    logic          m_valid_reg;
    logic          s_acc;
    logic          at_check;
    logic          frame_end;
    logic          is_hdr;

    assign at_check      = (phase_reg == PH_COLLECT) && (idx_reg == CHECK_BYTE);
    assign s_axis_tready = (sq_reg == SQ_IDLE) && !(at_check && m_valid_reg);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign frame_end     = s_acc && at_check;
    assign is_hdr        = (s_axis_tdata == HDR_NORMAL) || (s_axis_tdata >= HDR_MIN_ALT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            idx_reg    <= '0;
            hold_reg   <= '0;
            sum_reg    <= '0;
            fields_reg <= '0;
            sum_ok_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_hdr)
                    begin
                        hold_reg  <= s_axis_tdata;
                        phase_reg <= PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (s_axis_tdata == SYNC_BYTE)
                    begin
                        phase_reg <= PH_COLLECT;
                        idx_reg   <= FIELD_FIRST;
                        sum_reg   <= '0;
                    end
                    else if (is_hdr)
                        hold_reg <= s_axis_tdata;
                    else
                        phase_reg <= PH_HUNT;
                end
                PH_COLLECT:
                begin
                    if (idx_reg == CHECK_BYTE)
                    begin
                        sum_ok_reg <= (sum_reg == s_axis_tdata);
                        phase_reg  <= PH_HUNT;
                        idx_reg    <= '0;
                        sum_reg    <= '0;
                    end
                    else
                    begin
                        if (idx_reg <= FIELD_LAST)
                            fields_reg <= {fields_reg[135:0], s_axis_tdata};
                        sum_reg <= sum_reg + s_axis_tdata;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: phase_reg <= PH_HUNT;
            endcase
        end
    end

    // Sequencer over the three channels: 0 voltage, 1 current, 2 power.
    logic [1:0]        ch_reg;
    logic              sc_step_reg;
    logic              zero_reg;
    logic [63:0]       prod_reg;
    logic [VAL_W-1:0]  res_reg, v_reg, c_reg, p_reg;
    logic [111:0]      out_reg;
    logic [DSR_W-1:0]  param, data;
    logic [VAL_W-1:0]  mul_a, mul_b;
    logic              div_start, div_busy, div_done;
    logic [VAL_W-1:0]  div_q;
    logic [1:0]        status;

    always_comb
    begin
        case (ch_reg)
            2'd0:    begin param = fields_reg[143:120]; data = fields_reg[119:96]; end
            2'd1:    begin param = fields_reg[95:72];   data = fields_reg[71:48];  end
            default: begin param = fields_reg[47:24];   data = fields_reg[23:0];   end
        endcase
    end

    always_comb
    begin
        if (sq_reg == SQ_MUL)
        begin
            mul_a = VAL_W'(param);
            mul_b = (ch_reg == 2'd1) ? current_coef_reg : voltage_coef_reg;
        end
        else
        begin
            mul_a = res_reg;
            if (ch_reg == 2'd1)
                mul_b = current_gain_reg;
            else
                mul_b = sc_step_reg ? power_gain_reg : current_coef_reg;
        end
    end

    assign div_start = (sq_reg == SQ_DIV_GO);

    pmfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[DVD_W-1:0]),
        .divisor  (data),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (!sum_ok_reg)
            status = STATUS_CHECKSUM;
        else if (zero_reg)
            status = STATUS_ZERO_DIV;
        else
            status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg      <= SQ_IDLE;
            ch_reg      <= '0;
            sc_step_reg <= 1'b0;
            zero_reg    <= 1'b0;
            prod_reg    <= '0;
            res_reg     <= '0;
            v_reg       <= '0;
            c_reg       <= '0;
            p_reg       <= '0;
            out_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // A result leaving while the next one is loaded keeps valid high.
            if (m_valid_reg && m_axis_tready && (sq_reg != SQ_OUT))
                m_valid_reg <= 1'b0;
            case (sq_reg)
                SQ_IDLE:
                begin
                    if (frame_end)
                    begin
                        ch_reg   <= '0;
                        zero_reg <= 1'b0;
                        sq_reg   <= SQ_MUL;
                    end
                end
                SQ_MUL:
                begin
                    sc_step_reg <= 1'b0;
                    if (data == '0)
                    begin
                        res_reg  <= SAT32;
                        zero_reg <= 1'b1;
                        sq_reg   <= SQ_NEXT;
                    end
                    else
                    begin
                        prod_reg <= mul_a * mul_b;
                        sq_reg   <= SQ_DIV_GO;
                    end
                end
                SQ_DIV_GO:   sq_reg <= SQ_DIV_WAIT;
                SQ_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        res_reg <= div_q;
                        sq_reg  <= (ch_reg == 2'd0) ? SQ_NEXT : SQ_SC_MUL;
                    end
                end
                SQ_SC_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                    sq_reg   <= SQ_SC_SAT;
                end
                SQ_SC_SAT:
                begin
                    res_reg <= (|prod_reg[63:48]) ? SAT32 : prod_reg[47:16];
                    if (ch_reg == 2'd2 && !sc_step_reg)
                    begin
                        sc_step_reg <= 1'b1;
                        sq_reg      <= SQ_SC_MUL;
                    end
                    else
                        sq_reg <= SQ_NEXT;
                end
                SQ_NEXT:
                begin
                    case (ch_reg)
                        2'd0:    v_reg <= res_reg;
                        2'd1:    c_reg <= res_reg;
                        default: p_reg <= res_reg;
                    endcase
                    if (ch_reg == 2'd2)
                        sq_reg <= SQ_OUT;
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                        sq_reg <= SQ_MUL;
                    end
                end
                SQ_OUT:
                begin
                    // The output register takes the result once it is free.
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        if (sum_ok_reg)
                            out_reg <= {6'd0, p_reg, c_reg, v_reg, status, hold_reg};
                        else
                            out_reg <= {6'd0, {3*VAL_W{1'b0}}, status, hold_reg};
                        m_valid_reg <= 1'b1;
                        sq_reg      <= SQ_IDLE;
                    end
                end
                default: sq_reg <= SQ_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    `PMFD_ASSERT_SAME(a_busy_no_input, sq_reg != SQ_IDLE, !s_axis_tready)
    `PMFD_ASSERT_SAME(a_status_legal, m_axis_tvalid, m_axis_tdata[9:8] != 2'd3)
    `PMFD_ASSERT_NEXT(a_frame_starts_seq, frame_end, sq_reg == SQ_MUL)
    `PMFD_ASSERT_SAME(a_div_free_at_start, div_start, !div_busy)

endmodule

@@ verif/power_meter_frame_decoder_top_test.sv @@
// Self-checking testbench for power_meter_frame_decoder_top: serial bytes in, decoded
// meter readings out. Depends on pmfd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module power_meter_frame_decoder_top_test;
    import pmfd_pkg::*;

    typedef enum logic [1:0] {HUNTING, AWAIT_SYNC, COLLECTING} frame_phase_t;

    // One decoded meter reading as it leaves the block on m_axis.
    typedef struct {
        logic [7:0]  state_byte;
        logic [1:0]  status;
        logic [31:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
    } reading_t;

    // Generous bound on the run; far above what a slow but correct run needs.
    localparam int CYCLE_LIMIT = 3000000;
    // Covers the arithmetic of a frame end, with plenty on top.
    localparam int SETTLE_CYCLES = 400;

    // Scoreboard: follows the framer byte by byte, predicts each reading and
    // compares the readings that come out against the oldest prediction.
    class reading_board;
        logic [31:0]  coef [4];
        frame_phase_t phase;
        logic [4:0]   pos;
        logic [7:0]   held_state;
        logic [7:0]   sum;
        logic [23:0]  field [6];
        reading_t     pending [$];
        int           errors;

        function new();
            foreach (coef[i]) coef[i] = 32'h0001_0000;
            phase = HUNTING;
            pos = '0;
            held_state = '0;
            sum = '0;
            errors = 0;
        endfunction

        function bit is_header(logic [7:0] b);
            return b == HDR_NORMAL || b >= HDR_MIN_ALT;
        endfunction

        function logic [63:0] clamp(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
        endfunction

        // param * coefficient / data, saturated; a zero divisor gives all ones.
        function logic [63:0] quotient(logic [23:0] p, logic [23:0] d, logic [31:0] k,
                                       ref bit zero);
            if (d == 0)
            begin
                zero = 1'b1;
                return 64'hFFFF_FFFF;
            end
            return clamp((64'(p) * 64'(k)) / 64'(d));
        endfunction

        function logic [63:0] apply_gain(logic [63:0] v, logic [31:0] q);
            return clamp((v * 64'(q)) >> 16);
        endfunction

        function reading_t predict_reading(logic [7:0] check);
            reading_t r;
            bit zero;
            logic [63:0] v, c, p;
            zero = 1'b0;
            v = quotient(field[0], field[1], coef[REG_VOLTAGE_COEF], zero);
            c = quotient(field[2], field[3], coef[REG_CURRENT_COEF], zero);
            if (field[3] != 0)
                c = apply_gain(c, coef[REG_CURRENT_GAIN]);
            p = quotient(field[4], field[5], coef[REG_VOLTAGE_COEF], zero);
            if (field[5] != 0)
                p = apply_gain(apply_gain(p, coef[REG_CURRENT_COEF]), coef[REG_POWER_GAIN]);
            r.state_byte = held_state;
            if (sum != check)
            begin
                r.status = STATUS_CHECKSUM;
                v = 0;
                c = 0;
                p = 0;
            end
            else if (zero)
                r.status = STATUS_ZERO_DIV;
            else
                r.status = STATUS_OK;
            r.voltage = v[31:0];
            r.current = c[31:0];
            r.power = p[31:0];
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                HUNTING:
                    if (is_header(b))
                    begin
                        held_state = b;
                        phase = AWAIT_SYNC;
                    end
                AWAIT_SYNC:
                    if (b == SYNC_BYTE)
                    begin
                        phase = COLLECTING;
                        pos = FIELD_FIRST;
                        sum = '0;
                    end
                    else if (is_header(b))
                        held_state = b;
                    else
                        phase = HUNTING;
                default:
                    if (pos < CHECK_BYTE)
                    begin
                        if (pos <= FIELD_LAST)
                            field[(pos - FIELD_FIRST) / 3] =
                                {field[(pos - FIELD_FIRST) / 3][15:0], b};
                        sum += b;
                        pos++;
                    end
                    else
                    begin
                        pending.push_back(predict_reading(b));
                        phase = HUNTING;
                        pos = '0;
                        sum = '0;
                    end
            endcase
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_reading(logic [111:0] d);
            reading_t e;
            if (pending.size() == 0)
            begin
                $error("reading arrived with none expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("state_byte", e.state_byte, d[7:0]);
            compare("status", e.status, d[9:8]);
            compare("voltage", e.voltage, d[41:10]);
            compare("current", e.current, d[73:42]);
            compare("power", e.power, d[105:74]);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [7:0] state_byte, [9:8] status, [41:10] voltage, [73:42] current,
    // [105:74] power, [111:106] zero
    logic [111:0]         m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    reading_board board = new();
    int  send_idle_pct;   // chance in percent that the sender idles a cycle
    int  recv_stall_pct;  // chance in percent that the receiver stalls a cycle
    int  hold_off;        // cycles of forced receiver hold-off still to run
    longint cycles;

    power_meter_frame_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock and the watchdog that ends a hung run.
    initial
    begin
        clk = 1'b0;
        cycles = 0;
        forever
        begin
            #5 clk = ~clk;
            if (clk)
            begin
                cycles++;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Result side. Every transfer seen at an edge is checked; then tready is
    // chosen for the next cycle, honoring any forced hold-off first.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_reading(m_axis_tdata);
            if (hold_off > 0)
            begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Writes one register while the block is idle and mirrors it in the board.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.coef[idx] = value;
        @(posedge clk);
    endtask

    // Offers one byte and returns at the edge where it was accepted. The
    // valid stays high on return so that back-to-back bytes need no gap.
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_byte(b);
    endtask

    // A 24-bit field value biased toward the edges of its range.
    function automatic logic [23:0] pick_field(bit divisor);
        case ($urandom_range(7))
            0: return divisor ? 24'h0 : 24'hFF_FFFF;
            1: return 24'hFF_FFFF;
            2: return 24'h1;
            3: return 24'(($urandom_range(255)));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_header();
        case ($urandom_range(3))
            0, 1: return HDR_NORMAL;
            default: return 8'($urandom_range(255, 240));
        endcase
    endfunction

    // Sends one complete frame; the checksum is corrupted when asked.
    task automatic send_frame(logic [7:0] hdr, logic [23:0] f [6], bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        send_byte(hdr);
        send_byte(SYNC_BYTE);
        for (int i = 0; i < 6; i++)
            for (int k = 2; k >= 0; k--)
            begin
                b = f[i][k*8 +: 8];
                sum += b;
                send_byte(b);
            end
        for (int i = 0; i < 3; i++)
        begin
            b = 8'($urandom);
            sum += b;
            send_byte(b);
        end
        send_byte(bad_sum ? sum ^ 8'(($urandom_range(255, 1))) : sum);
    endtask

    task automatic send_random_frame();
        logic [23:0] f [6];
        for (int i = 0; i < 6; i++)
            f[i] = pick_field(i % 2 == 1);
        send_frame(pick_header(), f, $urandom_range(99) < 15);
    endtask

    // Junk on the line: random bytes and headers that are not followed by sync.
    task automatic send_noise();
        repeat ($urandom_range(4, 1))
            case ($urandom_range(3))
                0: send_byte(8'($urandom));
                1:
                begin
                    send_byte(pick_header());
                    send_byte(8'($urandom_range(255)) == SYNC_BYTE ? 8'h00 : 8'h3C);
                end
                2:
                begin
                    send_byte(pick_header());
                    send_byte(pick_header());
                end
                default: send_byte(8'($urandom_range(0, 84)));
            endcase
    endtask

    // Stops offering and waits until every predicted reading has come out,
    // then lets any work that produces no reading finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(int n_bytes);
        for (int sent = 0; sent < n_bytes; )
        begin
            if ($urandom_range(99) < 80)
            begin
                send_random_frame();
                sent += 24;
            end
            else
            begin
                send_noise();
                sent += 3;
            end
        end
    endtask

    initial
    begin
        logic [23:0] f [6];
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Directed part at reset coefficients of 1.0. A plain good frame.
        f = '{24'd1000, 24'd500, 24'd300, 24'd100, 24'd2000, 24'd400};
        send_frame(HDR_NORMAL, f, 1'b0);
        // Largest params over the smallest data: every value saturates.
        f = '{24'hFF_FFFF, 24'h1, 24'hFF_FFFF, 24'h1, 24'hFF_FFFF, 24'h1};
        send_frame(8'hFF, f, 1'b0);
        // All data fields zero: saturated values and the zero-divisor status.
        f = '{24'h12_3456, 24'h0, 24'h1, 24'h0, 24'h0, 24'h0};
        send_frame(HDR_MIN_ALT, f, 1'b0);
        // A checksum mismatch outranks the zero divisor and clears the values.
        send_frame(HDR_NORMAL, f, 1'b1);
        // Repeated header candidates before sync; the last one is kept.
        send_byte(HDR_NORMAL);
        send_byte(8'hF3);
        f = '{24'h0, 24'hFF_FFFF, 24'h0, 24'hFF_FFFF, 24'h0, 24'hFF_FFFF};
        send_frame(8'hF7, f, 1'b0);
        // A header broken by a stray byte sends the framer back to hunting.
        send_byte(HDR_NORMAL);
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        drain();

        // Random phases, each under its own coefficient set and idling mode.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 86; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 86; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default:
                begin
                    send_idle_pct = $urandom_range(30);
                    recv_stall_pct = $urandom_range(30);
                end
            endcase
            case (ph)
                1:
                    for (int r = 0; r < 4; r++)
                        write_reg(r[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
                2:
                    for (int r = 0; r < 4; r++)
                        write_reg(r[CFG_IDX_W-1:0], 32'h0);
                3:
                    for (int r = 0; r < 4; r++)
                        write_reg(r[CFG_IDX_W-1:0], 32'h0001_0000);
                default:
                    for (int r = 0; r < 4; r++)
                        write_reg(r[CFG_IDX_W-1:0], ($urandom_range(1) == 0) ?
                                  32'($urandom_range(32'h0004_0000)) : $urandom);
            endcase
            // Hold the result side off for a long stretch while frames keep
            // coming, so the output register fills and input stalls.
            if (ph == 5)
                hold_off = 3000;
            random_traffic(150);
            drain();
        end

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
